### design/line_rasterizer_page_framebuffer_core_defines.svh
// Assertion macros for the line rasterizer checker.
`ifndef LINE_RASTERIZER_PAGE_FRAMEBUFFER_CORE_DEFINES_SVH
`define LINE_RASTERIZER_PAGE_FRAMEBUFFER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LRPF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
   else $error(msg);

// Next-cycle implication, disabled during reset.
`define LRPF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
   else $error(msg);

`endif

### design/lrpf_pkg.sv
// Package: screen geometry, payload types and control types of the line rasterizer.
package lrpf_pkg;

   localparam int SCREEN_WIDTH  = 128;
   localparam int SCREEN_HEIGHT = 64;
   localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
   localparam int FB_BYTES      = PAGE_COUNT * SCREEN_WIDTH;
   localparam int FB_AW         = $clog2(FB_BYTES);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [6:0]          x_type;
   typedef logic [5:0]          y_type;
   typedef logic [7:0]          byte_type;
   typedef logic [9:0]          index_type;
   typedef logic [FB_AW-1:0]    fb_addr_type;
   typedef logic [QUEUE_AW-1:0] qptr_type;
   typedef logic [QUEUE_CW-1:0] qcnt_type;
   typedef logic signed [8:0]   err_type;

   typedef enum logic {
      ACT_DRAW = 1'b0,
      ACT_READ = 1'b1
   } action_type;

   typedef struct packed {
      action_type action;
      x_type      start_x;
      y_type      start_y;
      x_type      end_x;
      y_type      end_y;
      logic       pixel_on;
      index_type  read_index;
   } req_type;

   typedef struct packed {
      byte_type read_data;
      logic     was_read;
   } rsp_type;

   // Classified command with line setup already worked out
   typedef struct packed {
      action_type action;
      logic       pixel_on;
      x_type      x0;
      y_type      y0;
      x_type      x1;
      y_type      y1;
      x_type      abs_dx;
      y_type      abs_dy;
      logic       sx_neg;
      logic       sy_neg;
      index_type  read_index;
   } cmd_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_WAIT,
      ST_LN_READ,
      ST_LN_WRITE
   } back_state_type;

endpackage

### design/lrpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lrpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/lrpf_front.sv
// Front end: accepts transactions, classifies them and computes line setup.
module lrpf_front (
   input  logic                      start,
   output logic                      busy,
   input  lrpf_pkg::req_type         req_data,
   input  lrpf_pkg::back_status_type back_status,
   input  logic                      queue_full,
   output logic                      push,
   output lrpf_pkg::cmd_type         push_cmd
);

   assign busy = back_status.clearing | queue_full;
   assign push = start & ~busy;

   always_comb begin
      push_cmd.action     = req_data.action;
      push_cmd.pixel_on   = req_data.pixel_on;
      push_cmd.x0         = req_data.start_x;
      push_cmd.y0         = req_data.start_y;
      push_cmd.x1         = req_data.end_x;
      push_cmd.y1         = req_data.end_y;
      push_cmd.read_index = req_data.read_index;
      push_cmd.abs_dx     = (req_data.end_x > req_data.start_x) ?
                            (req_data.end_x - req_data.start_x) :
                            (req_data.start_x - req_data.end_x);
      push_cmd.abs_dy     = (req_data.end_y > req_data.start_y) ?
                            (req_data.end_y - req_data.start_y) :
                            (req_data.start_y - req_data.end_y);
      // step down unless strictly below the far endpoint
      push_cmd.sx_neg     = !(req_data.start_x < req_data.end_x);
      push_cmd.sy_neg     = !(req_data.start_y < req_data.end_y);
   end

endmodule

### design/lrpf_cmd_queue.sv
// Short command queue between the front end and the line walker.
module lrpf_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lrpf_pkg::cmd_type push_cmd,
   input  logic              pop,
   output lrpf_pkg::cmd_type head_cmd,
   output logic              empty,
   output logic              full
);

   lrpf_pkg::cmd_type  entry_ff [lrpf_pkg::QUEUE_DEPTH];
   lrpf_pkg::qptr_type wr_ptr_ff, wr_ptr_in;
   lrpf_pkg::qptr_type rd_ptr_ff, rd_ptr_in;
   lrpf_pkg::qcnt_type count_ff, count_in;

   localparam lrpf_pkg::qptr_type LastPtr = lrpf_pkg::qptr_type'(lrpf_pkg::QUEUE_DEPTH - 1);
   localparam lrpf_pkg::qcnt_type FullCnt = lrpf_pkg::qcnt_type'(lrpf_pkg::QUEUE_DEPTH);

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == FullCnt);
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### design/lrpf_back.sv
// Back end: framebuffer clearing pass, Bresenham walker with byte RMW, and reads.
module lrpf_back (
   input  logic                      clock,
   input  logic                      reset,
   input  lrpf_pkg::cmd_type         head_cmd,
   input  logic                      queue_empty,
   output logic                      pop,
   output lrpf_pkg::back_status_type back_status,
   output logic                      rsp_valid,
   output lrpf_pkg::rsp_type         rsp_data
);

   localparam lrpf_pkg::fb_addr_type LastAddr =
      lrpf_pkg::fb_addr_type'(lrpf_pkg::FB_BYTES - 1);

   lrpf_pkg::back_state_type state_ff, state_in;
   lrpf_pkg::fb_addr_type    clear_cnt_ff, clear_cnt_in;
   lrpf_pkg::x_type          cur_x_ff, cur_x_in, end_x_ff, end_x_in, dx_ff, dx_in;
   lrpf_pkg::y_type          cur_y_ff, cur_y_in, end_y_ff, end_y_in, dy_ff, dy_in;
   lrpf_pkg::err_type        err_ff, err_in;
   logic                     sx_neg_ff, sx_neg_in, sy_neg_ff, sy_neg_in;
   logic                     on_ff, on_in, rd_ok_ff, rd_ok_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   lrpf_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   logic                     ram_wr_en;
   lrpf_pkg::fb_addr_type    ram_wr_addr, ram_rd_addr, pix_addr;
   lrpf_pkg::byte_type       ram_wr_data, ram_rd_data, pix_mask;
   logic                     pix_ok, at_end, step_x, step_y;
   logic signed [9:0]        twice, dx_s, dy_s, err_w, err_sum;
   int                       pix_idx;

   lrpf_ram #(
      .WIDTH (8),
      .DEPTH (lrpf_pkg::FB_BYTES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Pixel address and bit of the current walk position
   always_comb begin
      pix_idx  = int'(cur_y_ff[5:3]) * lrpf_pkg::SCREEN_WIDTH + int'(cur_x_ff);
      pix_addr = lrpf_pkg::fb_addr_type'(pix_idx);
      pix_ok   = (int'(cur_x_ff) < lrpf_pkg::SCREEN_WIDTH) &&
                 (int'(cur_y_ff) < lrpf_pkg::SCREEN_HEIGHT) &&
                 (pix_idx < lrpf_pkg::FB_BYTES);
      pix_mask = 8'd1 << cur_y_ff[2:0];
   end

   // Bresenham step decision from the current error
   always_comb begin
      err_w   = 10'(err_ff);
      dx_s    = signed'({3'b000, dx_ff});
      dy_s    = signed'({4'b0000, dy_ff});
      twice   = err_w <<< 1;
      step_x  = (twice >= -dy_s);
      step_y  = (twice <= dx_s);
      err_sum = err_w - (step_x ? dy_s : 10'sd0) + (step_y ? dx_s : 10'sd0);
      at_end  = (cur_x_ff == end_x_ff) && (cur_y_ff == end_y_ff);
   end

   always_comb begin
      state_in     = state_ff;
      clear_cnt_in = clear_cnt_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      end_x_in     = end_x_ff;
      end_y_in     = end_y_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      err_in       = err_ff;
      sx_neg_in    = sx_neg_ff;
      sy_neg_in    = sy_neg_ff;
      on_in        = on_ff;
      rd_ok_in     = rd_ok_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = pix_addr;
      ram_wr_data  = on_ff ? (ram_rd_data | pix_mask) : (ram_rd_data & ~pix_mask);
      ram_rd_addr  = pix_addr;

      unique case (state_ff)
         lrpf_pkg::ST_CLEAR: begin
            ram_wr_en    = 1'b1;
            ram_wr_addr  = clear_cnt_ff;
            ram_wr_data  = '0;
            clear_cnt_in = clear_cnt_ff + 1'b1;
            if (clear_cnt_ff == LastAddr) begin
               state_in = lrpf_pkg::ST_IDLE;
            end
         end
         lrpf_pkg::ST_IDLE: begin
            if (!queue_empty) begin
               pop = 1'b1;
               if (head_cmd.action == lrpf_pkg::ACT_READ) begin
                  ram_rd_addr = lrpf_pkg::fb_addr_type'(head_cmd.read_index);
                  rd_ok_in    = (int'(head_cmd.read_index) < lrpf_pkg::FB_BYTES);
                  state_in    = lrpf_pkg::ST_RD_WAIT;
               end else begin
                  cur_x_in  = head_cmd.x0;
                  cur_y_in  = head_cmd.y0;
                  end_x_in  = head_cmd.x1;
                  end_y_in  = head_cmd.y1;
                  dx_in     = head_cmd.abs_dx;
                  dy_in     = head_cmd.abs_dy;
                  sx_neg_in = head_cmd.sx_neg;
                  sy_neg_in = head_cmd.sy_neg;
                  on_in     = head_cmd.pixel_on;
                  err_in    = signed'({2'b00, head_cmd.abs_dx}) -
                              signed'({3'b000, head_cmd.abs_dy});
                  state_in  = lrpf_pkg::ST_LN_READ;
               end
            end
         end
         lrpf_pkg::ST_RD_WAIT: begin
            rsp_valid_in          = 1'b1;
            rsp_data_in.read_data = rd_ok_ff ? ram_rd_data : '0;
            rsp_data_in.was_read  = 1'b1;
            state_in              = lrpf_pkg::ST_IDLE;
         end
         lrpf_pkg::ST_LN_READ: begin
            // read address is the current pixel byte
            state_in = lrpf_pkg::ST_LN_WRITE;
         end
         lrpf_pkg::ST_LN_WRITE: begin
            ram_wr_en = pix_ok;
            if (at_end) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.read_data = '0;
               rsp_data_in.was_read  = 1'b0;
               state_in              = lrpf_pkg::ST_IDLE;
            end else begin
               err_in = err_sum[8:0];
               if (step_x) begin
                  cur_x_in = sx_neg_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
               end
               if (step_y) begin
                  cur_y_in = sy_neg_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
               end
               state_in = lrpf_pkg::ST_LN_READ;
            end
         end
         default: state_in = lrpf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lrpf_pkg::ST_CLEAR;
         clear_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         err_ff       <= '0;
         dx_ff        <= '0;
         dy_ff        <= '0;
         sx_neg_ff    <= 1'b0;
         sy_neg_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         err_ff       <= err_in;
         dx_ff        <= dx_in;
         dy_ff        <= dy_in;
         sx_neg_ff    <= sx_neg_in;
         sy_neg_ff    <= sy_neg_in;
      end
   end

   always_ff @(posedge clock) begin
      end_x_ff    <= end_x_in;
      end_y_ff    <= end_y_in;
      on_ff       <= on_in;
      rd_ok_ff    <= rd_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign back_status.clearing = (state_ff == lrpf_pkg::ST_CLEAR);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_data             = rsp_data_ff;

endmodule

### design/line_rasterizer_page_framebuffer_core.sv
// Top level: line rasterizer over a 1-bit-per-pixel page-layout framebuffer.
//
// A transaction is taken when start is high and busy is low. A draw-line
// transaction walks the Bresenham line between its endpoints and sets or
// clears every pixel by a read-modify-write of the framebuffer byte; a read
// transaction returns one byte. Every transaction yields one result, shown on
// rsp_data for a single cycle with rsp_valid high; the receiver cannot stall,
// so results must be taken when they appear. A read goes from the queue
// head through ST_RD_WAIT to a registered result; a line does a read and
// then a write of the framebuffer byte for each pixel. A two-entry queue
// lets the next transaction be taken while one is being drawn. After reset
// a clearing pass writes zero to all 1024 bytes, one a cycle, and busy stays
// high throughout the pass.
module line_rasterizer_page_framebuffer_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lrpf_pkg::req_type req_data,
   output logic              rsp_valid,
   output lrpf_pkg::rsp_type rsp_data
);

   lrpf_pkg::back_status_type back_status;
   lrpf_pkg::cmd_type         push_cmd, head_cmd;
   logic                      push, pop, queue_empty, queue_full;

   lrpf_front u_front (
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .back_status (back_status),
      .queue_full  (queue_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   lrpf_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   lrpf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_cmd    (head_cmd),
      .queue_empty (queue_empty),
      .pop         (pop),
      .back_status (back_status),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

### design/lrpf_checker.sv
// Port-level checker for the line rasterizer, bound to the top level.
`include "line_rasterizer_page_framebuffer_core_defines.svh"

module lrpf_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input lrpf_pkg::req_type req_data,
   input logic              rsp_valid,
   input lrpf_pkg::rsp_type rsp_data
);

   `LRPF_ASSERT_IMP(a_busy_after_reset, clock, reset, $fell(reset), busy,
      "busy low during clear")
   `LRPF_ASSERT_NEXT(a_rsp_spaced, clock, reset, rsp_valid, !rsp_valid,
      "back-to-back results")
   `LRPF_ASSERT_IMP(a_line_zero, clock, reset, rsp_valid && !rsp_data.was_read,
      rsp_data.read_data == 8'd0, "line result carries data")
   // hold a refused transaction until it is taken
   `LRPF_ASSERT_NEXT(a_req_held, clock, reset, start && busy,
      start && $stable(req_data), "transaction dropped while busy")

endmodule

bind line_rasterizer_page_framebuffer_core lrpf_checker u_lrpf_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
